/* src/pci_bus_enumerator_assert.svh */
// Assertion macros for the PCI bus enumerator.
`ifndef PCI_BUS_ENUMERATOR_ASSERT_SVH
`define PCI_BUS_ENUMERATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define PBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbe assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbe assertion failed");
`else
`define PBE_ASSERT_NOW(lbl, ante, cons)
`define PBE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/pbe_pkg.sv */
// Types, codes and helpers shared by the PCI bus enumerator files.
`timescale 1ns / 1ps
package pbe_pkg;

  localparam logic IN_START = 1'b0;
  localparam logic IN_RESP  = 1'b1;

  localparam logic [15:0] NO_VENDOR     = 16'hFFFF;
  localparam logic [7:0]  OFF_ID        = 8'h00;
  localparam logic [7:0]  OFF_CLASS     = 8'h08;
  localparam logic [7:0]  OFF_HDR       = 8'h0C;
  localparam logic [7:0]  OFF_BAR0      = 8'h10;
  localparam logic [7:0]  OFF_IRQ       = 8'h3C;
  localparam int          HDR_MULTI_BIT = 23;   // header type bit 7 in the word

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    RES_REQ    = 2'd0,
    RES_RECORD = 2'd1,
    RES_BAR    = 2'd2,
    RES_DONE   = 2'd3
  } pbe_kind_res_t;

  typedef enum logic [3:0] {
    PH_DEV_ID    = 4'd0,
    PH_HDR       = 4'd1,
    PH_FN_ID     = 4'd2,
    PH_REC_ID    = 4'd3,
    PH_REC_CLASS = 4'd4,
    PH_REC_IRQ   = 4'd5,
    PH_BAR0      = 4'd6,
    PH_BAR1      = 4'd7,
    PH_BAR2      = 4'd8,
    PH_BAR3      = 4'd9,
    PH_BAR4      = 4'd10,
    PH_BAR5      = 4'd11
  } pbe_phase_t;

  typedef struct packed {
    pbe_kind_res_t kind_res;
    logic [7:0]    bus;
    logic [4:0]    device_num;
    logic [2:0]    function_res;
    logic [7:0]    offset;
    logic [15:0]   vendor_id;
    logic [15:0]   device_id;
    logic [7:0]    base_class;
    logic [7:0]    subclass;
    logic [7:0]    prog_if;
    logic [7:0]    irq_line;
    logic [31:0]   bar_value;
  } pbe_result_t;

  typedef struct packed {
    logic first;
    logic second;
  } pbe_push_t;

  // scan position and result after moving to the next function or device
  typedef struct packed {
    logic [7:0]  bus;
    logic [4:0]  dev;
    logic [2:0]  fn;
    logic        scan;
    pbe_phase_t  phase;
    pbe_result_t res;
  } pbe_adv_t;

  function automatic pbe_result_t mk_req(logic [7:0] b, logic [4:0] d, logic [2:0] f,
                                         logic [7:0] off);
    pbe_result_t r;
    r = '0;
    r.kind_res     = RES_REQ;
    r.bus          = b;
    r.device_num   = d;
    r.function_res = f;
    r.offset       = off;
    return r;
  endfunction

  function automatic logic [7:0] bar_off(pbe_phase_t ph);
    logic [3:0] idx;
    idx = 4'(ph) - 4'(PH_BAR0);
    return OFF_BAR0 + {2'b00, idx, 2'b00};
  endfunction

endpackage

/* src/pbe_in_if.sv */
// Input channel of the PCI bus enumerator: start and read response words.
`timescale 1ns / 1ps
interface pbe_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] read_data;

  modport source (output valid, kind, read_data, input ready);
  modport sink   (input valid, kind, read_data, output ready);
endinterface

/* src/pbe_out_if.sv */
// Result channel of the PCI bus enumerator: requests, records, BAR words, done.
`timescale 1ns / 1ps
interface pbe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_res;
  logic [7:0]  bus;
  logic [4:0]  device_num;
  logic [2:0]  function_res;
  logic [7:0]  offset;
  logic [15:0] vendor_id;
  logic [15:0] device_id;
  logic [7:0]  base_class;
  logic [7:0]  subclass;
  logic [7:0]  prog_if;
  logic [7:0]  irq_line;
  logic [31:0] bar_value;

  modport source (output valid, kind_res, bus, device_num, function_res, offset, vendor_id,
                  device_id, base_class, subclass, prog_if, irq_line, bar_value,
                  input ready);
  modport sink   (input valid, kind_res, bus, device_num, function_res, offset, vendor_id,
                  device_id, base_class, subclass, prog_if, irq_line, bar_value,
                  output ready);
endinterface

/* src/pbe_core.sv */
// Scan sequencer: position, read phase and device count, one word per cycle while accept is high.
`timescale 1ns / 1ps
`include "pci_bus_enumerator_assert.svh"
module pbe_core #(
  parameter int MAX_DEVICES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                kind,
  input  logic [31:0]         read_data,
  output pbe_pkg::pbe_push_t  push,
  output pbe_pkg::pbe_result_t res0,
  output pbe_pkg::pbe_result_t res1
);

  localparam int CNT_W = $clog2(MAX_DEVICES + 1);

  logic                scanning_r, scanning_nxt;
  logic [7:0]          bus_r, bus_nxt;
  logic [4:0]          dev_r, dev_nxt;
  logic [2:0]          fn_r, fn_nxt;
  logic                multi_r, multi_nxt;
  pbe_pkg::pbe_phase_t phase_r, phase_nxt;
  logic [31:0]         held_id_r, held_id_nxt;
  logic [31:0]         held_class_r, held_class_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  pbe_pkg::pbe_adv_t   adv_dev, adv_fn;

  function automatic pbe_pkg::pbe_adv_t advance(logic try_fn, logic [7:0] b, logic [4:0] d,
                                                 logic [2:0] f, logic multi);
    pbe_pkg::pbe_adv_t a;
    a.bus   = b;
    a.dev   = d;
    a.fn    = f;
    a.scan  = 1'b1;
    a.phase = pbe_pkg::PH_FN_ID;
    a.res   = '0;
    if (try_fn && multi && f != 3'd7) begin
      a.fn  = f + 3'd1;
      a.res = pbe_pkg::mk_req(b, d, a.fn, pbe_pkg::OFF_ID);
    end else begin
      a.fn    = 3'd0;
      a.phase = pbe_pkg::PH_DEV_ID;
      if (d == 5'd31) begin
        a.dev = 5'd0;
        if (b == 8'hFF) begin
          a.bus          = 8'd0;
          a.scan         = 1'b0;
          a.res.kind_res = pbe_pkg::RES_DONE;
        end else begin
          a.bus = b + 8'd1;
        end
      end else begin
        a.dev = d + 5'd1;
      end
      if (a.scan) begin
        a.res = pbe_pkg::mk_req(a.bus, a.dev, 3'd0, pbe_pkg::OFF_ID);
      end
    end
    return a;
  endfunction

  assign adv_dev = advance(1'b0, bus_r, dev_r, fn_r, multi_r);
  assign adv_fn  = advance(1'b1, bus_r, dev_r, fn_r, multi_r);

  always_comb begin
    scanning_nxt   = scanning_r;
    bus_nxt        = bus_r;
    dev_nxt        = dev_r;
    fn_nxt         = fn_r;
    multi_nxt      = multi_r;
    phase_nxt      = phase_r;
    held_id_nxt    = held_id_r;
    held_class_nxt = held_class_r;
    count_nxt      = count_r;
    push           = '0;
    res0           = '0;
    res1           = '0;
    if (accept) begin
      if (kind == pbe_pkg::IN_START) begin
        if (!scanning_r) begin
          scanning_nxt = 1'b1;
          bus_nxt      = 8'd0;
          dev_nxt      = 5'd0;
          fn_nxt       = 3'd0;
          multi_nxt    = 1'b0;
          count_nxt    = '0;
          phase_nxt    = pbe_pkg::PH_DEV_ID;
          push.first   = 1'b1;
          res0         = pbe_pkg::mk_req(8'd0, 5'd0, 3'd0, pbe_pkg::OFF_ID);
        end
      end else if (scanning_r) begin
        case (phase_r)
          pbe_pkg::PH_DEV_ID: begin
            push.first = 1'b1;
            if (read_data[15:0] == pbe_pkg::NO_VENDOR) begin
              bus_nxt      = adv_dev.bus;
              dev_nxt      = adv_dev.dev;
              fn_nxt       = adv_dev.fn;
              scanning_nxt = adv_dev.scan;
              phase_nxt    = adv_dev.phase;
              res0         = adv_dev.res;
            end else begin
              phase_nxt = pbe_pkg::PH_HDR;
              res0      = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::OFF_HDR);
            end
          end
          pbe_pkg::PH_HDR: begin
            push.first = 1'b1;
            multi_nxt  = read_data[pbe_pkg::HDR_MULTI_BIT];
            fn_nxt     = 3'd0;
            phase_nxt  = pbe_pkg::PH_FN_ID;
            res0       = pbe_pkg::mk_req(bus_r, dev_r, 3'd0, pbe_pkg::OFF_ID);
          end
          pbe_pkg::PH_FN_ID: begin
            push.first = 1'b1;
            if (read_data[15:0] == pbe_pkg::NO_VENDOR ||
                count_r >= CNT_W'(MAX_DEVICES)) begin
              bus_nxt      = adv_fn.bus;
              dev_nxt      = adv_fn.dev;
              fn_nxt       = adv_fn.fn;
              scanning_nxt = adv_fn.scan;
              phase_nxt    = adv_fn.phase;
              res0         = adv_fn.res;
            end else begin
              phase_nxt = pbe_pkg::PH_REC_ID;
              res0      = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::OFF_ID);
            end
          end
          pbe_pkg::PH_REC_ID: begin
            push.first  = 1'b1;
            held_id_nxt = read_data;
            phase_nxt   = pbe_pkg::PH_REC_CLASS;
            res0        = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::OFF_CLASS);
          end
          pbe_pkg::PH_REC_CLASS: begin
            push.first     = 1'b1;
            held_class_nxt = read_data;
            phase_nxt      = pbe_pkg::PH_REC_IRQ;
            res0           = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::OFF_IRQ);
          end
          pbe_pkg::PH_REC_IRQ: begin
            push.first        = 1'b1;
            push.second       = 1'b1;
            count_nxt         = count_r + CNT_W'(1);
            res0.kind_res     = pbe_pkg::RES_RECORD;
            res0.bus          = bus_r;
            res0.device_num   = dev_r;
            res0.function_res = fn_r;
            res0.vendor_id    = held_id_r[15:0];
            res0.device_id    = held_id_r[31:16];
            res0.base_class   = held_class_r[31:24];
            res0.subclass     = held_class_r[23:16];
            res0.prog_if      = held_class_r[15:8];
            res0.irq_line     = read_data[7:0];
            phase_nxt         = pbe_pkg::PH_BAR0;
            res1              = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::OFF_BAR0);
          end
          default: begin
            if (phase_r inside {[pbe_pkg::PH_BAR0:pbe_pkg::PH_BAR5]}) begin
              push.first        = 1'b1;
              push.second       = 1'b1;
              res0.kind_res     = pbe_pkg::RES_BAR;
              res0.bus          = bus_r;
              res0.device_num   = dev_r;
              res0.function_res = fn_r;
              res0.offset       = pbe_pkg::bar_off(phase_r);
              res0.bar_value    = read_data;
              if (phase_r != pbe_pkg::PH_BAR5) begin
                phase_nxt = pbe_pkg::pbe_phase_t'(4'(phase_r) + 4'd1);
                res1      = pbe_pkg::mk_req(bus_r, dev_r, fn_r, pbe_pkg::bar_off(phase_nxt));
              end else begin
                bus_nxt      = adv_fn.bus;
                dev_nxt      = adv_fn.dev;
                fn_nxt       = adv_fn.fn;
                scanning_nxt = adv_fn.scan;
                phase_nxt    = adv_fn.phase;
                res1         = adv_fn.res;
              end
            end else begin
              scanning_nxt = 1'b0;
              phase_nxt    = pbe_pkg::PH_DEV_ID;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      bus_r      <= 8'd0;
      dev_r      <= 5'd0;
      fn_r       <= 3'd0;
      multi_r    <= 1'b0;
      phase_r    <= pbe_pkg::PH_DEV_ID;
      count_r    <= '0;
    end else begin
      scanning_r <= scanning_nxt;
      bus_r      <= bus_nxt;
      dev_r      <= dev_nxt;
      fn_r       <= fn_nxt;
      multi_r    <= multi_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_id_r    <= held_id_nxt;
    held_class_r <= held_class_nxt;
  end

  `PBE_ASSERT_NOW(a_idle_phase, !scanning_r, phase_r == pbe_pkg::PH_DEV_ID)
  `PBE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_DEVICES))
  `PBE_ASSERT_NXT(a_start_scans, accept && kind == pbe_pkg::IN_START, scanning_r)
  `PBE_ASSERT_NOW(a_pair_only_bar, push.second, phase_r >= pbe_pkg::PH_REC_IRQ)

endmodule

/* src/pbe_out_queue.sv */
// Result queue: takes up to two words per cycle, releases one per cycle while dout_ready is high.
`timescale 1ns / 1ps
`include "pci_bus_enumerator_assert.svh"
module pbe_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pbe_pkg::pbe_push_t   push,
  input  pbe_pkg::pbe_result_t din0,
  input  pbe_pkg::pbe_result_t din1,
  output logic                 space,
  output logic                 dout_valid,
  input  logic                 dout_ready,
  output pbe_pkg::pbe_result_t dout
);

  pbe_pkg::pbe_result_t              q_r [pbe_pkg::QDEPTH];
  logic [pbe_pkg::QPTR_W-1:0]        wr_r, wr_nxt;
  logic [pbe_pkg::QPTR_W-1:0]        rd_r, rd_nxt;
  logic [pbe_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [1:0]                        n_push;
  logic                              pop;

  assign space      = cnt_r <= pbe_pkg::QCNT_W'(pbe_pkg::QDEPTH - 2);
  assign dout_valid = cnt_r != '0;
  assign dout       = q_r[rd_r];
  assign pop        = dout_valid && dout_ready;
  assign n_push     = {1'b0, push.first} + {1'b0, push.second};

  always_comb begin
    wr_nxt  = wr_r + pbe_pkg::QPTR_W'(n_push);
    rd_nxt  = rd_r + pbe_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + pbe_pkg::QCNT_W'(n_push) - pbe_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      q_r[wr_r] <= din0;
    end
    if (push.second) begin
      q_r[wr_r + pbe_pkg::QPTR_W'(1)] <= din1;
    end
  end

  `PBE_ASSERT_NOW(a_no_overflow, push.first, space)
  `PBE_ASSERT_NOW(a_pair_order, push.second, push.first)
  `PBE_ASSERT_NXT(a_push_shows, push.first, dout_valid)

endmodule

/* src/pci_bus_enumerator.sv */
// Top level of the PCI bus enumerator.
// Usage:
//   in_ch carries one word per handshake: kind 0 starts a scan (ignored while a
//   scan runs), kind 1 is the 32-bit word returned for the last read request
//   (ignored while idle). out_ch carries read requests, device records, BAR
//   words and a final done word. The host answers every read request with one
//   response word on in_ch.
// Output: with an empty queue the first result of an accepted word shows on
//   out_ch in the next cycle. Throughput: one input word per cycle while
//   in_ch.ready is high; a word yields at most two results, which leave
//   through a four-entry result queue at one per cycle as out_ch takes them.
//   in_ch.ready drops while the queue holds more than two entries, so the queue
//   depth and the output drain rate set the input rate under backpressure.
// Reset (rst_n low, synchronous): idle, position and device count cleared,
//   result queue emptied.
// Stall: when out_ch.ready is low the queue fills and then in_ch.ready goes
//   low; nothing is dropped.
`timescale 1ns / 1ps
module pci_bus_enumerator #(
  parameter int MAX_DEVICES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pbe_in_if.sink      in_ch,
  pbe_out_if.source   out_ch
);

  pbe_pkg::pbe_push_t   push;
  pbe_pkg::pbe_result_t res0, res1, head;
  logic                 space;
  logic                 accept;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  pbe_core #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_ch.kind),
    .read_data (in_ch.read_data),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  pbe_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din0       (res0),
    .din1       (res1),
    .space      (space),
    .dout_valid (out_ch.valid),
    .dout_ready (out_ch.ready),
    .dout       (head)
  );

  assign out_ch.kind_res     = head.kind_res;
  assign out_ch.bus          = head.bus;
  assign out_ch.device_num   = head.device_num;
  assign out_ch.function_res = head.function_res;
  assign out_ch.offset       = head.offset;
  assign out_ch.vendor_id    = head.vendor_id;
  assign out_ch.device_id    = head.device_id;
  assign out_ch.base_class   = head.base_class;
  assign out_ch.subclass     = head.subclass;
  assign out_ch.prog_if      = head.prog_if;
  assign out_ch.irq_line     = head.irq_line;
  assign out_ch.bar_value    = head.bar_value;

endmodule
